[rtl/lru_table_with_victim_placement_macros.svh]
// Assertion macros for the LRU table with victim placement.
`ifndef LRU_TABLE_WITH_VICTIM_PLACEMENT_MACROS_SVH
`define LRU_TABLE_WITH_VICTIM_PLACEMENT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define LRUT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrut check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define LRUT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrut check failed");
`else
`define LRUT_ASSERT_NOW(label, ante, cons)
`define LRUT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/lrut_pkg.sv]
// Shared constants and request codes for the LRU table with victim placement.
package lrut_pkg;

  // Table geometry
  localparam int ENTRIES    = 64;
  localparam int NODES      = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;

  // Fixed field widths of the request and response beats
  localparam int TYPE_W  = 3;
  localparam int TAG_W   = 32;
  localparam int DATA_W  = 64;
  localparam int NIDX_W  = 4;
  localparam int STAMP_W = 64;

  // Derived widths
  localparam int ENTRY_AW = $clog2(ENTRIES);
  localparam int ENTRY_CW = $clog2(ENTRIES + 1);
  localparam int NODE_AW  = $clog2(NODES);

  // Request codes
  localparam logic [TYPE_W-1:0] OP_GET    = 3'd0;
  localparam logic [TYPE_W-1:0] OP_UPDATE = 3'd1;
  localparam logic [TYPE_W-1:0] OP_ADMIT  = 3'd2;
  localparam logic [TYPE_W-1:0] OP_EVICT  = 3'd3;
  localparam logic [TYPE_W-1:0] OP_VICTIM = 3'd4;
  localparam logic [TYPE_W-1:0] OP_NEIGH  = 3'd5;
  localparam logic [TYPE_W-1:0] OP_PLACE  = 3'd6;

endpackage

[rtl/lrut_if.sv]
// Request and response channel interfaces with valid/ready handshake.
interface lrut_req_if;
  logic                         valid;
  logic                         ready;
  logic [lrut_pkg::TYPE_W-1:0]  req_type;
  logic [lrut_pkg::TAG_W-1:0]   key_tag;
  logic [lrut_pkg::DATA_W-1:0]  new_value;
  logic [lrut_pkg::NIDX_W-1:0]  neighbor_index;
  logic [lrut_pkg::STAMP_W-1:0] neighbor_stamp;

  modport source (output valid, req_type, key_tag, new_value, neighbor_index,
                  neighbor_stamp, input ready);
  modport sink   (input valid, req_type, key_tag, new_value, neighbor_index,
                  neighbor_stamp, output ready);
endinterface

interface lrut_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic                         success;
  logic [lrut_pkg::DATA_W-1:0]  result_value;
  logic [lrut_pkg::TAG_W-1:0]   result_key;
  logic [lrut_pkg::STAMP_W-1:0] result_stamp;
  logic [lrut_pkg::NIDX_W-1:0]  placement_node;

  modport source (output valid, found, success, result_value, result_key,
                  result_stamp, placement_node, input ready);
  modport sink   (input valid, found, success, result_value, result_key,
                  result_stamp, placement_node, output ready);
endinterface

[rtl/lru_table_with_victim_placement.sv]
// Top level: fully associative LRU key/value table with neighbor-based placement.
//
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------------------
//  req     | in  | req_type, key_tag, new_value, neighbor_index, neighbor_stamp
//  rsp     | out | found, success, result_value, result_key, result_stamp,
//          |     | placement_node
//  cfg     | in  | cfg_we, cfg_wdata = own_node_index
//
// Get, update, admit, evict and victim query scan every entry, commit in S_ACT and
// load the output register from S_OUT; the input reopens in S_IDLE after that load.
// Placement takes a setup state (S_PINIT) and a neighbor scan over all NODES slots in
// place of S_ACT. Neighbor update and the unused code go straight to S_OUT.
// The entry scan makes one RAM read per cycle on one shared stamp comparator.
// Reset clears valid bits, clock and neighbor flags at once; a held beat stalls only
// the next result.
`include "lru_table_with_victim_placement_macros.svh"

module lru_table_with_victim_placement (
  input  logic                        clk,
  input  logic                        rst,
  lrut_req_if.sink                    req,
  lrut_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [lrut_pkg::NIDX_W-1:0] cfg_wdata
);
  import lrut_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_PINIT = 3'd3;
  localparam logic [2:0] S_NSCAN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;

  // Configuration
  logic [NIDX_W-1:0] own;

  // Latched request
  logic [TYPE_W-1:0]     op;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // Table state
  logic                  valid_q [ENTRIES];
  logic [STAMP_W-1:0]    vclk;
  logic                  nb_known [NODES];
  logic [STAMP_W-1:0]    nb_stamp [NODES];

  // Scan trackers
  logic [ENTRY_CW-1:0]   cnt;
  logic [NODE_AW-1:0]    nj;
  logic                  hit;
  logic [ENTRY_AW-1:0]   hit_slot;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  free_found;
  logic [ENTRY_AW-1:0]   free_slot;
  logic                  vic_found;
  logic [KEY_BITS-1:0]   vic_key;
  logic [STAMP_W-1:0]    vic_stamp;
  logic [STAMP_W-1:0]    best;
  logic [NODE_AW-1:0]    pnode;

  // Pending result
  logic                  res_found;
  logic                  res_success;
  logic [DATA_W-1:0]     res_value;
  logic [TAG_W-1:0]      res_key;
  logic [STAMP_W-1:0]    res_stamp;
  logic [NIDX_W-1:0]     res_pnode;

  // Output register
  logic                  out_valid;
  logic                  out_found;
  logic                  out_success;
  logic [DATA_W-1:0]     out_value;
  logic [TAG_W-1:0]      out_key;
  logic [STAMP_W-1:0]    out_stamp;
  logic [NIDX_W-1:0]     out_pnode;

  // RAM ports
  logic                  key_we, val_we, stamp_we;
  logic [ENTRY_AW-1:0]   wr_addr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic                  rd_en;
  logic [ENTRY_AW-1:0]   rd_addr;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [STAMP_W-1:0]    stamp_rd;

  // Scan helpers
  logic [ENTRY_AW-1:0]   e_idx;
  logic                  e_valid;
  logic                  key_match;
  logic [STAMP_W-1:0]    cmp_a, cmp_b;
  logic                  cmp_lt;
  logic                  nb_take;
  logic                  act_insert;
  logic                  req_fire;
  logic                  out_load;

  assign req.ready = (state == S_IDLE) && !rst;
  assign req_fire  = req.valid && req.ready;
  assign out_load  = (state == S_OUT) && (!out_valid || rsp.ready);

  // Entry delivered by the RAM this cycle was addressed in the previous cycle
  assign e_idx     = ENTRY_AW'(cnt - ENTRY_CW'(1));
  assign e_valid   = valid_q[e_idx];
  assign key_match = e_valid && (key_rd == key_q);

  // Shared stamp comparator: entry stamps while scanning, neighbor stamps after
  always_comb begin
    if (state == S_NSCAN) begin
      cmp_a = nb_stamp[nj];
      cmp_b = best;
    end else begin
      cmp_a = stamp_rd;
      cmp_b = vic_stamp;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  assign nb_take = nb_known[nj] && (32'(nj) != 32'(own)) && cmp_lt;

  // Admit into the first free slot
  assign act_insert = (state == S_ACT) && (op == OP_ADMIT) && !hit && free_found;

  // RAM read and write control
  assign rd_en   = (state == S_SCAN) && (32'(cnt) < ENTRIES);
  assign rd_addr = ENTRY_AW'(cnt);

  always_comb begin
    key_we    = 1'b0;
    val_we    = 1'b0;
    stamp_we  = 1'b0;
    wr_addr   = hit_slot;
    val_wdata = val_q;
    if (state == S_ACT) begin
      case (op)
        OP_GET: begin
          stamp_we = hit;
        end
        OP_UPDATE: begin
          val_we   = hit;
          stamp_we = hit;
        end
        OP_ADMIT: begin
          if (act_insert) begin
            wr_addr  = free_slot;
            key_we   = 1'b1;
            val_we   = 1'b1;
            stamp_we = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  lrut_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_q),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lrut_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_addr),
    .wdata (val_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

  lrut_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (wr_addr),
    .wdata (vclk),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (stamp_rd)
  );

  // Hold the own node index
  always_ff @(posedge clk) begin
    if (rst) begin
      own <= '0;
    end else if (cfg_we) begin
      own <= cfg_wdata;
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      nj    <= '0;
      vclk  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
      for (int i = 0; i < NODES; i++) begin
        nb_known[i] <= 1'b0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            cnt <= '0;
            if (req.req_type == OP_NEIGH) begin
              if ((req.neighbor_index != own) && (32'(req.neighbor_index) < NODES)) begin
                nb_known[NODE_AW'(req.neighbor_index)] <= 1'b1;
              end
              state <= S_OUT;
            end else if (req.req_type == OP_GET || req.req_type == OP_UPDATE ||
                         req.req_type == OP_ADMIT || req.req_type == OP_EVICT ||
                         req.req_type == OP_VICTIM || req.req_type == OP_PLACE) begin
              state <= S_SCAN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + ENTRY_CW'(1);
          if (32'(cnt) == ENTRIES) begin
            state <= (op == OP_PLACE) ? S_PINIT : S_ACT;
          end
        end
        S_ACT: begin
          if (op == OP_GET || op == OP_UPDATE || act_insert) begin
            vclk <= vclk + STAMP_W'(1);
          end
          if (act_insert) begin
            valid_q[free_slot] <= 1'b1;
          end
          if (op == OP_EVICT && hit) begin
            valid_q[hit_slot] <= 1'b0;
          end
          state <= S_OUT;
        end
        S_PINIT: begin
          nj    <= '0;
          state <= S_NSCAN;
        end
        S_NSCAN: begin
          nj <= nj + NODE_AW'(1);
          if (32'(nj) == NODES - 1) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the request, track the scan and build the result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          op          <= req.req_type;
          key_q       <= KEY_BITS'(req.key_tag);
          val_q       <= VALUE_BITS'(req.new_value);
          hit         <= 1'b0;
          free_found  <= 1'b0;
          vic_found   <= 1'b0;
          vic_stamp   <= '0;
          vic_key     <= '0;
          res_found   <= 1'b0;
          res_success <= 1'b0;
          res_value   <= '0;
          res_key     <= '0;
          res_stamp   <= '0;
          res_pnode   <= '0;
          if ((req.req_type == OP_NEIGH) && (req.neighbor_index != own) &&
              (32'(req.neighbor_index) < NODES)) begin
            nb_stamp[NODE_AW'(req.neighbor_index)] <= req.neighbor_stamp;
          end
        end
      end
      S_SCAN: begin
        if (cnt != '0) begin
          if (key_match && !hit) begin
            hit       <= 1'b1;
            hit_slot  <= e_idx;
            hit_value <= val_rd;
          end
          if (!e_valid && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= e_idx;
          end
          if (e_valid && (!vic_found || cmp_lt)) begin
            vic_found <= 1'b1;
            vic_stamp <= stamp_rd;
            vic_key   <= key_rd;
          end
        end
      end
      S_ACT: begin
        case (op)
          OP_GET: begin
            res_found <= hit;
            res_value <= hit ? DATA_W'(hit_value) : '0;
          end
          OP_UPDATE: begin
            res_found   <= hit;
            res_success <= hit;
          end
          OP_ADMIT: begin
            res_found   <= hit;
            res_success <= hit || free_found;
          end
          OP_EVICT: begin
            res_found <= hit;
            res_value <= hit ? DATA_W'(hit_value) : '0;
          end
          OP_VICTIM: begin
            res_found <= vic_found;
            res_key   <= TAG_W'(vic_key);
            res_stamp <= vic_stamp;
          end
          default: begin
          end
        endcase
      end
      S_PINIT: begin
        best      <= vic_stamp;
        pnode     <= NODE_AW'(own);
        res_stamp <= vic_stamp;
      end
      S_NSCAN: begin
        if (nb_take) begin
          best  <= cmp_a;
          pnode <= nj;
        end
        if (32'(nj) == NODES - 1) begin
          res_pnode <= nb_take ? NIDX_W'(nj) : NIDX_W'(pnode);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load when the slot is free, drop on a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found   <= res_found;
      out_success <= res_success;
      out_value   <= res_value;
      out_key     <= res_key;
      out_stamp   <= res_stamp;
      out_pnode   <= res_pnode;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.found          = out_found;
  assign rsp.success        = out_success;
  assign rsp.result_value   = out_value;
  assign rsp.result_key     = out_key;
  assign rsp.result_stamp   = out_stamp;
  assign rsp.placement_node = out_pnode;

  // A taken request closes the input until its result is built
  `LRUT_ASSERT_NEXT(a_busy_after_accept, req_fire, !req.ready)
  // The virtual clock moves only when an access is committed
  `LRUT_ASSERT_NEXT(a_clock_only_in_act, state != S_ACT, vclk == $past(vclk))
  // An inserting admit leaves its slot marked valid
  `LRUT_ASSERT_NEXT(a_insert_sets_valid, act_insert, valid_q[$past(free_slot)])
  // A waiting result is never overwritten by the next one
  `LRUT_ASSERT_NOW(a_no_overwrite, out_load && out_valid, rsp.ready)

endmodule

[rtl/lrut_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lrut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
